// ===== design/jc_pkg.sv =====
package jc_pkg;

    localparam int CAL_W   = 15;   // calibration and dead band width
    localparam int AXIS_W  = 16;   // raw and normalized axis width
    localparam int HOLD_W  = 16;   // debounce hold time width
    localparam int TIME_W  = 32;   // timestamp width
    localparam int CFG_AW  = 5;    // byte address width of the register port
    localparam int CFG_DW  = 32;   // register port data width

    // divider steps for a 16 bit quotient
    localparam int DIV_STEPS = AXIS_W;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_X_CENTER    = 3'd0;
    localparam logic [2:0] REG_X_MIN       = 3'd1;
    localparam logic [2:0] REG_X_MAX       = 3'd2;
    localparam logic [2:0] REG_Y_CENTER    = 3'd3;
    localparam logic [2:0] REG_Y_MIN       = 3'd4;
    localparam logic [2:0] REG_Y_MAX       = 3'd5;
    localparam logic [2:0] REG_DEAD_BAND   = 3'd6;
    localparam logic [2:0] REG_DEBOUNCE_MS = 3'd7;

    // reset values
    localparam logic [CAL_W-1:0]  RST_CENTER    = 15'd13200;
    localparam logic [CAL_W-1:0]  RST_MIN       = 15'd0;
    localparam logic [CAL_W-1:0]  RST_MAX       = 15'd26400;
    localparam logic [CAL_W-1:0]  RST_DEAD_BAND = 15'd3277;
    localparam logic [HOLD_W-1:0] RST_DEBOUNCE  = 16'd50;

    // calibration of one axis
    typedef struct packed {
        logic [CAL_W-1:0] center;
        logic [CAL_W-1:0] lo;
        logic [CAL_W-1:0] hi;
    } t_axis_cal;

endpackage

// ===== design/jc_axis_lane.sv =====
module jc_axis_lane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [15:0]          i_raw,
    input  jc_pkg::t_axis_cal           i_cal,
    input  logic [14:0]                 i_dead_band,
    output logic                        o_busy,
    output logic signed [15:0]          o_norm
);
    import jc_pkg::*;

    localparam int          CNT_W    = $clog2(DIV_STEPS + 3);
    localparam logic [CNT_W-1:0] CNT_PREP = CNT_W'(DIV_STEPS + 2);
    localparam logic [CNT_W-1:0] CNT_FIN  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_IDLE = CNT_W'(0);

    localparam logic [AXIS_W-1:0] LIM_POS = {1'b0, {(AXIS_W-1){1'b1}}};
    localparam logic [AXIS_W-1:0] LIM_NEG = {1'b1, {(AXIS_W-1){1'b0}}};

    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [AXIS_W-1:0]  r_mag,   n_mag;
    logic               r_neg,   n_neg;
    logic [CAL_W-1:0]   r_range, n_range;
    logic               r_sat,   n_sat;
    logic [CAL_W-1:0]   r_rem,   n_rem;
    logic               r_feed,  n_feed;
    logic [AXIS_W-1:0]  r_quo,   n_quo;
    logic [AXIS_W-1:0]  r_norm,  n_norm;

    logic signed [AXIS_W:0] d;
    logic signed [AXIS_W:0] c_ext;
    logic signed [AXIS_W:0] range_raw;
    logic [AXIS_W-1:0]      trial;
    logic [AXIS_W-1:0]      limit;
    logic [AXIS_W-1:0]      qmag;

    always_comb begin
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_range = r_range;
        n_sat   = r_sat;
        n_rem   = r_rem;
        n_feed  = r_feed;
        n_quo   = r_quo;
        n_norm  = r_norm;

        c_ext     = {2'b00, i_cal.center};
        d         = {i_raw[AXIS_W-1], i_raw} - c_ext;
        range_raw = d[AXIS_W] ? (c_ext - {2'b00, i_cal.lo}) : ({2'b00, i_cal.hi} - c_ext);
        trial     = {r_rem, r_feed};
        limit     = r_neg ? LIM_NEG : LIM_POS;
        qmag      = (r_sat || (r_quo > limit)) ? limit : r_quo;

        if (i_start) begin
            n_cnt = CNT_PREP;
            n_neg = d[AXIS_W];
            n_mag = d[AXIS_W] ? AXIS_W'(-d) : d[AXIS_W-1:0];
            // inverted or degenerate calibration gives a range of one
            n_range = (range_raw < 17'sd1) ? CAL_W'(1) : range_raw[CAL_W-1:0];
        end else if (r_cnt == CNT_PREP) begin
            // quotient needs more than 16 bits when |d| >= 2*range
            n_sat  = ({1'b0, r_mag} >= {1'b0, r_range, 1'b0});
            n_rem  = r_mag[AXIS_W-1:1];
            n_feed = r_mag[0];
            n_quo  = '0;
            n_cnt  = r_cnt - CNT_W'(1);
        end else if (r_cnt > CNT_FIN) begin
            // one restoring step
            if (trial >= {1'b0, r_range}) begin
                n_rem = CAL_W'(trial - {1'b0, r_range});
                n_quo = {r_quo[AXIS_W-2:0], 1'b1};
            end else begin
                n_rem = trial[CAL_W-1:0];
                n_quo = {r_quo[AXIS_W-2:0], 1'b0};
            end
            n_feed = 1'b0;
            n_cnt  = r_cnt - CNT_W'(1);
        end else if (r_cnt == CNT_FIN) begin
            if (qmag < {1'b0, i_dead_band}) begin
                n_norm = '0;
            end else begin
                n_norm = r_neg ? AXIS_W'(-qmag) : qmag;
            end
            n_cnt = CNT_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_IDLE;
        end else begin
            r_cnt <= n_cnt;
        end
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_range <= n_range;
        r_sat   <= n_sat;
        r_rem   <= n_rem;
        r_feed  <= n_feed;
        r_quo   <= n_quo;
        r_norm  <= n_norm;
    end

    assign o_busy = (r_cnt != CNT_IDLE);
    assign o_norm = r_norm;

endmodule

// ===== design/jc_debounce.sv =====
module jc_debounce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sample,
    input  logic [31:0] i_time,
    input  logic        i_btn,
    input  logic [15:0] i_hold,
    output logic        o_stable
);
    import jc_pkg::*;

    logic              r_last,   n_last;
    logic [TIME_W-1:0] r_change, n_change;
    logic              r_stable, n_stable;
    logic              changed;
    logic [TIME_W-1:0] elapsed;

    always_comb begin
        n_last   = r_last;
        n_change = r_change;
        n_stable = r_stable;
        changed  = (i_btn != r_last);
        // a fresh edge restarts the timer: elapsed is zero
        elapsed  = changed ? '0 : (i_time - r_change);
        if (i_sample) begin
            if (changed) begin
                n_change = i_time;
                n_last   = i_btn;
            end
            if (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, i_hold}) begin
                n_stable = i_btn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b0;
            r_change <= '0;
            r_stable <= 1'b0;
        end else begin
            r_last   <= n_last;
            r_change <= n_change;
            r_stable <= n_stable;
        end
    end

    assign o_stable = r_stable;

endmodule

// ===== design/joystick_axis_and_button_conditioner_unit.sv =====
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_stall    i_time_ms i_button_raw i_adc_present
//                                                 i_raw_x i_raw_y
// out       from block o_out_valid / i_out_stall  o_button_pressed o_norm_x o_norm_y
//                                                 o_both_centered o_adc_warning
// cfg       to block   psel penable pwrite pready paddr pwdata prdata
//
// An accepted item passes through each axis lane as a load, a divider setup, 16 restoring
// steps and a saturate/deadzone step, and then enters the output register.
// Reset (i_rst_n low, synchronous) restores the calibration defaults and clears the
// debounce state and all handshake state.
// A result held under i_out_stall does not block acceptance; the next item is taken
// at once and its result waits in the lanes until the output register frees up.
module joystick_axis_and_button_conditioner_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_time_ms,
    input  logic               i_button_raw,
    input  logic               i_adc_present,
    input  logic signed [15:0] i_raw_x,
    input  logic signed [15:0] i_raw_y,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_button_pressed,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic               o_both_centered,
    output logic               o_adc_warning,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import jc_pkg::*;

    // calibration registers
    logic [CAL_W-1:0]  r_x_center, r_x_min, r_x_max;
    logic [CAL_W-1:0]  r_y_center, r_y_min, r_y_max;
    logic [CAL_W-1:0]  r_dead_band;
    logic [HOLD_W-1:0] r_debounce_ms;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_center    <= RST_CENTER;
            r_x_min       <= RST_MIN;
            r_x_max       <= RST_MAX;
            r_y_center    <= RST_CENTER;
            r_y_min       <= RST_MIN;
            r_y_max       <= RST_MAX;
            r_dead_band   <= RST_DEAD_BAND;
            r_debounce_ms <= RST_DEBOUNCE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_X_CENTER:    r_x_center    <= pwdata[CAL_W-1:0];
                REG_X_MIN:       r_x_min       <= pwdata[CAL_W-1:0];
                REG_X_MAX:       r_x_max       <= pwdata[CAL_W-1:0];
                REG_Y_CENTER:    r_y_center    <= pwdata[CAL_W-1:0];
                REG_Y_MIN:       r_y_min       <= pwdata[CAL_W-1:0];
                REG_Y_MAX:       r_y_max       <= pwdata[CAL_W-1:0];
                REG_DEAD_BAND:   r_dead_band   <= pwdata[CAL_W-1:0];
                REG_DEBOUNCE_MS: r_debounce_ms <= pwdata[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_X_CENTER:    prdata = {{(CFG_DW-CAL_W){1'b0}}, r_x_center};
            REG_X_MIN:       prdata = {{(CFG_DW-CAL_W){1'b0}}, r_x_min};
            REG_X_MAX:       prdata = {{(CFG_DW-CAL_W){1'b0}}, r_x_max};
            REG_Y_CENTER:    prdata = {{(CFG_DW-CAL_W){1'b0}}, r_y_center};
            REG_Y_MIN:       prdata = {{(CFG_DW-CAL_W){1'b0}}, r_y_min};
            REG_Y_MAX:       prdata = {{(CFG_DW-CAL_W){1'b0}}, r_y_max};
            REG_DEAD_BAND:   prdata = {{(CFG_DW-CAL_W){1'b0}}, r_dead_band};
            REG_DEBOUNCE_MS: prdata = {{(CFG_DW-HOLD_W){1'b0}}, r_debounce_ms};
            default:         prdata = '0;
        endcase
    end

    // item control: r_busy covers the lanes' work and any wait for the output slot
    logic r_busy,    n_busy;
    logic r_present, n_present;
    logic accept;
    logic lanes_busy;
    logic out_load;
    logic x_busy, y_busy;
    logic signed [AXIS_W-1:0] x_norm, y_norm;
    logic button_stable;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_busy;
    assign lanes_busy = x_busy || y_busy;
    assign out_load   = r_busy && !lanes_busy && (!o_out_valid || !i_out_stall);

    t_axis_cal x_cal, y_cal;
    assign x_cal = '{center: r_x_center, lo: r_x_min, hi: r_x_max};
    assign y_cal = '{center: r_y_center, lo: r_y_min, hi: r_y_max};

    // one lane per axis, started together
    jc_axis_lane u_lane_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_raw       (i_raw_x),
        .i_cal       (x_cal),
        .i_dead_band (r_dead_band),
        .o_busy      (x_busy),
        .o_norm      (x_norm)
    );

    jc_axis_lane u_lane_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_raw       (i_raw_y),
        .i_cal       (y_cal),
        .i_dead_band (r_dead_band),
        .o_busy      (y_busy),
        .o_norm      (y_norm)
    );

    // button state updates on the accept edge; read back when the result is merged
    jc_debounce u_debounce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (accept),
        .i_time   (i_time_ms),
        .i_btn    (i_button_raw),
        .i_hold   (r_debounce_ms),
        .o_stable (button_stable)
    );

    always_comb begin
        n_busy    = r_busy;
        n_present = r_present;
        if (accept) begin
            n_busy    = 1'b1;
            n_present = i_adc_present;
        end else if (out_load) begin
            n_busy = 1'b0;
        end
    end

    // merge stage / output register
    logic                     r_out_valid;
    logic                     r_button;
    logic signed [AXIS_W-1:0] r_norm_x, r_norm_y;
    logic                     r_centered;
    logic                     r_warning;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_present <= n_present;
        if (out_load) begin
            r_button <= button_stable;
            if (r_present) begin
                r_norm_x   <= x_norm;
                r_norm_y   <= y_norm;
                r_centered <= (x_norm == '0) && (y_norm == '0);
                r_warning  <= 1'b0;
            end else begin
                // no converter: axes forced to rest
                r_norm_x   <= '0;
                r_norm_y   <= '0;
                r_centered <= 1'b1;
                r_warning  <= 1'b1;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_button_pressed = r_button;
    assign o_norm_x         = r_norm_x;
    assign o_norm_y         = r_norm_y;
    assign o_both_centered  = r_centered;
    assign o_adc_warning    = r_warning;

    // lanes share start and step count, so they must stay in lockstep
    a_lane_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_busy == y_busy)
        else $error("axis lanes out of step");

    // a result only enters the output register from an item in flight
    a_load_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy) && !$past(lanes_busy))
        else $error("result loaded without a finished item");

    // missing converter forces the axes to rest
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_adc_warning |->
            o_norm_x == '0 && o_norm_y == '0 && o_both_centered)
        else $error("axes not at rest with converter absent");

    // centered flag tracks the axes when the converter is present
    a_centered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_adc_warning |->
            o_both_centered == (o_norm_x == '0 && o_norm_y == '0))
        else $error("centered flag mismatch");

endmodule
